FILE: design/interrupt_vector_allocator_macros.svh
// Assertion helpers used by the checker file.
`ifndef INTERRUPT_VECTOR_ALLOCATOR_MACROS_SVH
`define INTERRUPT_VECTOR_ALLOCATOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IVA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IVA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/ivalloc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ivalloc_pkg;

  localparam int WORD_BITS = 64;
  localparam logic [7:0] PRESENT_CLEAR_MASK = 8'h7F;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_CLAIM   = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_CLAIM_USED   = 2'd2,
    ST_RELEASE_FREE = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic rd;
    logic upd;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alloc_op;
    logic hit;
    logic last_word;
  } sts_t;

  // Lowest set bit of one map word: {found, index}.
  function automatic logic [6:0] first_free(input logic [WORD_BITS-1:0] word);
    logic [6:0] res;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        res = {1'b1, 6'(i)};
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/ivalloc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ivalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/ivalloc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ivalloc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire ivalloc_pkg::sts_t  sts_i,
  output ivalloc_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        // advance word by word until a free bit or the end of the map
        if (!sts_i.alloc_op || sts_i.hit || sts_i.last_word) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

endmodule

`default_nettype wire

FILE: design/ivalloc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ivalloc_dp #(
  parameter int REACH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ivalloc_pkg::cmd_t cmd_i,
  output ivalloc_pkg::sts_t      sts_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [7:0]        vector_i,
  input  wire logic [7:0]        attributes_i,
  output logic      [7:0]        vector_out_o,
  output logic      [1:0]        status_o,
  output logic      [7:0]        stored_attributes_o
);

  localparam int IDX_W  = $clog2(REACH);
  localparam int WORDS  = (REACH + ivalloc_pkg::WORD_BITS - 1) / ivalloc_pkg::WORD_BITS;
  localparam int WCNT_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAP_W  = WORDS * ivalloc_pkg::WORD_BITS;

  ivalloc_pkg::opcode_e op_q;
  logic [7:0]           vec_q;
  logic [7:0]           attr_q;
  logic [WCNT_W-1:0]    word_q;
  logic [7:0]           tgt_q;
  logic                 none_q;
  logic [REACH-1:0]     free_map_q;
  logic [REACH-1:0]     written_q;
  logic [7:0]           vector_out_q;
  ivalloc_pkg::status_e status_q, status_d;
  logic [7:0]           stored_q, stored_d;

  logic [MAP_W-1:0]     scan_map;
  logic [ivalloc_pkg::WORD_BITS-1:0] scan_word;
  logic [6:0]           ff;
  logic                 last_word;
  logic [IDX_W-1:0]     tgt_idx;
  logic                 in_table;
  logic                 cur_free;
  logic [7:0]           ram_rdata;
  logic [7:0]           held;
  logic                 ram_we;
  logic [7:0]           ram_wdata;
  logic                 set_used;
  logic                 set_free;

  // Pad the map with used bits so the last word never reports a phantom vector
  assign scan_map  = MAP_W'(free_map_q);
  assign scan_word = scan_map[ivalloc_pkg::WORD_BITS * word_q +: ivalloc_pkg::WORD_BITS];
  assign ff        = ivalloc_pkg::first_free(scan_word);
  assign last_word = (word_q == WCNT_W'(WORDS - 1));

  assign sts_o.alloc_op  = (op_q == ivalloc_pkg::OP_ALLOC);
  assign sts_o.hit       = ff[6];
  assign sts_o.last_word = last_word;

  assign tgt_idx  = tgt_q[IDX_W-1:0];
  assign in_table = ({1'b0, tgt_q} < 9'(REACH));
  assign cur_free = free_map_q[tgt_idx];
  // never-written entries read as the reset value
  assign held     = written_q[tgt_idx] ? ram_rdata : 8'h00;

  ivalloc_ram #(
    .WIDTH(8),
    .DEPTH(REACH)
  ) u_attr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tgt_idx),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(tgt_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    status_d  = ivalloc_pkg::ST_OK;
    stored_d  = in_table ? held : 8'h00;
    ram_wdata = attr_q;
    set_used  = 1'b0;
    set_free  = 1'b0;
    unique case (op_q)
      ivalloc_pkg::OP_ALLOC: begin
        if (none_q) begin
          status_d = ivalloc_pkg::ST_NONE_FREE;
        end else begin
          set_used = 1'b1;
          stored_d = attr_q;
        end
      end
      ivalloc_pkg::OP_CLAIM: begin
        if (in_table && cur_free) begin
          set_used = 1'b1;
          stored_d = attr_q;
        end else begin
          status_d = ivalloc_pkg::ST_CLAIM_USED;
        end
      end
      ivalloc_pkg::OP_RELEASE: begin
        if (in_table && !cur_free) begin
          set_free  = 1'b1;
          ram_wdata = held & ivalloc_pkg::PRESENT_CLEAR_MASK;
          stored_d  = held & ivalloc_pkg::PRESENT_CLEAR_MASK;
        end else begin
          status_d = ivalloc_pkg::ST_RELEASE_FREE;
        end
      end
      default: ;
    endcase
  end

  assign ram_we = cmd_i.upd && (set_used || set_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q <= '1;
      written_q  <= '0;
    end else if (cmd_i.upd) begin
      if (set_used) begin
        free_map_q[tgt_idx] <= 1'b0;
        written_q[tgt_idx]  <= 1'b1;
      end
      if (set_free) begin
        free_map_q[tgt_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= ivalloc_pkg::opcode_e'(opcode_i);
      vec_q  <= vector_i;
      attr_q <= attributes_i;
      word_q <= '0;
      none_q <= 1'b0;
    end
    if (cmd_i.scan) begin
      if (op_q != ivalloc_pkg::OP_ALLOC) begin
        tgt_q <= vec_q;
      end else if (ff[6]) begin
        tgt_q <= 8'({word_q, ff[5:0]});
      end else if (last_word) begin
        tgt_q  <= 8'h00;
        none_q <= 1'b1;
      end else begin
        word_q <= word_q + 1'b1;
      end
    end
    if (cmd_i.upd) begin
      vector_out_q <= tgt_q;
      status_q     <= status_d;
      stored_q     <= stored_d;
    end
  end

  assign vector_out_o        = vector_out_q;
  assign status_o            = status_q;
  assign stored_attributes_o = stored_q;

endmodule

`default_nettype wire

FILE: design/interrupt_vector_allocator.sv
// Interrupt vector allocator: free map plus attribute byte per vector.
// Input channel (in_valid_i / in_stall_o) carries opcode, vector and
// attribute byte; a transfer happens on a clock edge with valid high and
// stall low. Output channel (out_valid_o / out_stall_i) carries the vector,
// a status and the attribute byte now held for that vector.
// One item is in flight at a time: in_stall_o stays high from the transfer
// until its result has been taken.
// Claim, release and the unused opcode pass once through the scan, read
// and update states, then the result is valid in the response state.
// Allocate stays in scan while W (1 to 4) 64-bit free-map words are
// scanned, one per cycle, up to the first free bit or the end of the map.
// The attribute memory has one registered read port, so each item passes
// through a read state and an update state. After its result is taken the
// block returns to idle before the next transfer.
// A stalled result holds its value and keeps the input stalled. Reset marks
// every vector free and every attribute byte zero at once; no clearing pass
// is needed.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_vector_allocator #(
  parameter int VECTOR_COUNT = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] vector_i,
  input  wire logic [7:0] attributes_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] vector_out_o,
  output logic      [1:0] status_o,
  output logic      [7:0] stored_attributes_o
);

  // only vectors an 8-bit field can name are kept
  localparam int REACH = (VECTOR_COUNT < 256) ? VECTOR_COUNT : 256;

  ivalloc_pkg::cmd_t cmd;
  ivalloc_pkg::sts_t sts;

  ivalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ivalloc_dp #(
    .REACH(REACH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .vector_i           (vector_i),
    .attributes_i       (attributes_i),
    .vector_out_o       (vector_out_o),
    .status_o           (status_o),
    .stored_attributes_o(stored_attributes_o)
  );

endmodule

`default_nettype wire

FILE: design/ivalloc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "interrupt_vector_allocator_macros.svh"

module ivalloc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] vector_out_o,
  input wire logic [1:0] status_o,
  input wire logic [7:0] stored_attributes_o
);

  // a pending result blocks new work
  `IVA_ASSERT(a_busy_while_result, out_valid_o |-> in_stall_o,
              "input open with result pending")

  `IVA_ASSERT(a_busy_after_transfer,
              (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o),
              "not busy after input transfer")

  `IVA_ASSERT(a_none_free_vector,
              (out_valid_o && status_o == ivalloc_pkg::ST_NONE_FREE) |-> (vector_out_o == 8'h00),
              "no-free result with nonzero vector")

  `IVA_ASSERT(a_stall_holds,
              (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(vector_out_o) &&
              $stable(status_o) && $stable(stored_attributes_o)),
              "stalled result changed")

  // reset takes hold by the next edge
  `IVA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind interrupt_vector_allocator ivalloc_checker u_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_VECTORS = 256;
  localparam int ITEM_TARGET = 1200;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_e;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKS} rx_mode_e;

  typedef struct {
    logic [1:0] opcode;
    logic [7:0] vector;
    logic [7:0] attributes;
    bit         wait_idle;
  } request_t;

  typedef struct {
    logic [7:0]           vector;
    ivalloc_pkg::status_e status;
    logic [7:0]           attributes;
  } grant_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i = 2'd0;
  logic [7:0] vector_i = 8'd0;
  logic [7:0] attributes_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] vector_out_o;
  logic [1:0] status_o;
  logic [7:0] stored_attributes_o;

  interrupt_vector_allocator #(
    .VECTOR_COUNT(NUM_VECTORS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .vector_i           (vector_i),
    .attributes_i       (attributes_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .vector_out_o       (vector_out_o),
    .status_o           (status_o),
    .stored_attributes_o(stored_attributes_o)
  );

  request_t   pending_requests[$];
  grant_t     expected_grants[$];
  request_t   current_request;

  // Predicted table contents
  bit         vec_free[NUM_VECTORS];
  logic [7:0] vec_attr[NUM_VECTORS];

  // Free map as seen by the stimulus planner
  bit         plan_free[NUM_VECTORS];
  int         plan_used = 0;
  int         planned = 0;

  // Handshake state sampled mid-cycle
  bit         in_xfer = 1'b0;
  bit         out_xfer = 1'b0;
  bit         results_idle = 1'b1;
  logic [7:0] got_vector;
  logic [1:0] got_status;
  logic [7:0] got_attributes;

  int         mismatches = 0;
  int         cycle_count = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  rx_mode_e   rx_mode = RX_OPEN;
  int         rx_left = 0;
  int         rx_period = 2;
  int         rx_duty = 1;
  int         rx_hold = 0;
  int         rx_tick = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic grant_t predict_grant(input request_t r);
    grant_t g;
    bit     hit;
    int     v;
    v = int'(r.vector);
    g.vector = r.vector;
    g.status = ivalloc_pkg::ST_OK;
    hit = 1'b0;
    case (r.opcode)
      ivalloc_pkg::OP_ALLOC: begin
        g.vector = 8'd0;
        g.status = ivalloc_pkg::ST_NONE_FREE;
        for (int i = 0; i < NUM_VECTORS && i < 256; i++) begin
          if (!hit && vec_free[i]) begin
            hit = 1'b1;
            vec_free[i] = 1'b0;
            vec_attr[i] = r.attributes;
            g.vector = 8'(i);
            g.status = ivalloc_pkg::ST_OK;
          end
        end
      end
      ivalloc_pkg::OP_CLAIM: begin
        if (v < NUM_VECTORS && vec_free[v]) begin
          vec_free[v] = 1'b0;
          vec_attr[v] = r.attributes;
        end else begin
          g.status = ivalloc_pkg::ST_CLAIM_USED;
        end
      end
      ivalloc_pkg::OP_RELEASE: begin
        if (v < NUM_VECTORS && !vec_free[v]) begin
          vec_free[v] = 1'b1;
          vec_attr[v] = vec_attr[v] & ivalloc_pkg::PRESENT_CLEAR_MASK;
        end else begin
          g.status = ivalloc_pkg::ST_RELEASE_FREE;
        end
      end
      default: ;
    endcase
    g.attributes = (int'(g.vector) < NUM_VECTORS) ? vec_attr[g.vector] : 8'h00;
    return g;
  endfunction

  // Random vector with the wanted free state, -1 when there is none.
  function automatic int find_vector(input bit want_free);
    int start;
    int idx;
    start = $urandom_range(0, NUM_VECTORS - 1);
    for (int i = 0; i < NUM_VECTORS; i++) begin
      idx = (start + i) % NUM_VECTORS;
      if (plan_free[idx] == want_free) return idx;
    end
    return -1;
  endfunction

  task automatic plan_request(input logic [1:0] op, input logic [7:0] vec,
                              input logic [7:0] attr, input bit wait_idle);
    request_t r;
    int       low;
    r.opcode = op;
    r.vector = vec;
    r.attributes = attr;
    r.wait_idle = wait_idle;
    case (op)
      ivalloc_pkg::OP_ALLOC: begin
        low = -1;
        for (int i = 0; i < NUM_VECTORS; i++) begin
          if (low < 0 && plan_free[i]) low = i;
        end
        if (low >= 0) begin
          plan_free[low] = 1'b0;
          plan_used++;
        end
      end
      ivalloc_pkg::OP_CLAIM: begin
        if (plan_free[vec]) begin
          plan_free[vec] = 1'b0;
          plan_used++;
        end
      end
      ivalloc_pkg::OP_RELEASE: begin
        if (!plan_free[vec]) begin
          plan_free[vec] = 1'b1;
          plan_used--;
        end
      end
      default: ;
    endcase
    if (op != OP_UNUSED) planned++;
    pending_requests.push_back(r);
  endtask

  initial begin : stimulus
    phase_e     phase;
    int         roll;
    int         idx;
    int         steps;
    int         tail;
    int         tail_len;
    int         mixed_len;
    int         drain_floor;
    int         cut_alloc;
    int         cut_claim;
    int         cut_release;
    bit         phase_done;
    bit         first;
    logic [1:0] op;
    logic [7:0] vec;

    for (int i = 0; i < NUM_VECTORS; i++) begin
      vec_free[i] = 1'b1;
      vec_attr[i] = 8'h00;
      plan_free[i] = 1'b1;
    end

    plan_request(ivalloc_pkg::OP_ALLOC, 8'hFF, 8'hFF, 1'b0);
    plan_request(ivalloc_pkg::OP_ALLOC, 8'h00, 8'h00, 1'b0);
    plan_request(ivalloc_pkg::OP_CLAIM, 8'hFF, 8'hA5, 1'b0);
    plan_request(ivalloc_pkg::OP_CLAIM, 8'hFF, 8'h5A, 1'b0);
    plan_request(ivalloc_pkg::OP_RELEASE, 8'hFF, 8'h00, 1'b0);
    plan_request(ivalloc_pkg::OP_RELEASE, 8'hFF, 8'hFF, 1'b0);
    plan_request(OP_UNUSED, 8'hFF, 8'hFF, 1'b0);
    plan_request(ivalloc_pkg::OP_CLAIM, 8'h00, 8'h3C, 1'b0);
    plan_request(ivalloc_pkg::OP_RELEASE, 8'h00, 8'h00, 1'b0);
    plan_request(ivalloc_pkg::OP_ALLOC, 8'h80, 8'h80, 1'b0);
    plan_request(ivalloc_pkg::OP_RELEASE, 8'h80, 8'h00, 1'b0);
    plan_request(ivalloc_pkg::OP_CLAIM, 8'h80, 8'h7F, 1'b0);
    plan_request(ivalloc_pkg::OP_CLAIM, 8'h02, 8'hC3, 1'b1);
    plan_request(ivalloc_pkg::OP_ALLOC, 8'h55, 8'hAA, 1'b0);
    plan_request(ivalloc_pkg::OP_RELEASE, 8'h01, 8'h00, 1'b0);
    plan_request(ivalloc_pkg::OP_ALLOC, 8'hAA, 8'h55, 1'b0);
    plan_request(OP_UNUSED, 8'h00, 8'h00, 1'b0);
    plan_request(OP_UNUSED, 8'h80, 8'h12, 1'b0);

    // Fill the table until allocation runs dry, mix, then drain it again.
    phase = PH_FILL;
    while (planned < ITEM_TARGET) begin
      steps = 0;
      tail = 0;
      tail_len = $urandom_range(6, 14);
      mixed_len = $urandom_range(60, 140);
      drain_floor = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 24);
      phase_done = 1'b0;
      first = 1'b1;
      case (phase)
        PH_FILL: begin
          cut_alloc = 70; cut_claim = 85; cut_release = 90;
        end
        PH_MIXED: begin
          cut_alloc = 35; cut_claim = 55; cut_release = 85;
        end
        default: begin
          cut_alloc = 8; cut_claim = 13; cut_release = 85;
        end
      endcase
      while (planned < ITEM_TARGET && !phase_done) begin
        roll = $urandom_range(0, 99);
        if (roll < cut_alloc) begin
          op = ivalloc_pkg::OP_ALLOC;
          vec = 8'($urandom_range(0, 255));
        end else if (roll < cut_claim) begin
          op = ivalloc_pkg::OP_CLAIM;
          idx = find_vector(1'b1);
          vec = (idx < 0) ? 8'($urandom_range(0, 255)) : 8'(idx);
        end else if (roll < cut_release) begin
          op = ivalloc_pkg::OP_RELEASE;
          idx = find_vector(1'b0);
          vec = (idx < 0) ? 8'($urandom_range(0, 255)) : 8'(idx);
        end else begin
          case ($urandom_range(0, 2))
            0: op = ivalloc_pkg::OP_CLAIM;
            1: op = ivalloc_pkg::OP_RELEASE;
            default: op = OP_UNUSED;
          endcase
          vec = 8'($urandom_range(0, 255));
        end
        plan_request(op, vec, 8'($urandom_range(0, 255)),
                     first || ($urandom_range(0, 99) == 0));
        first = 1'b0;
        steps++;
        case (phase)
          PH_FILL:  if (plan_used == NUM_VECTORS) tail++;
          PH_DRAIN: if (plan_used <= drain_floor) tail++;
          default:  if (steps >= mixed_len) tail = tail_len + 1;
        endcase
        phase_done = (tail > tail_len);
      end
      case (phase)
        PH_FILL:  phase = PH_MIXED;
        PH_MIXED: phase = PH_DRAIN;
        default:  phase = PH_FILL;
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_grants.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Sample handshakes between edges so the clocked blocks never race the block.
  always @(negedge clk_i) begin
    in_xfer = in_valid_i && (in_stall_o === 1'b0);
    out_xfer = (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
    got_vector = vector_out_o;
    got_status = status_o;
    got_attributes = stored_attributes_o;
    results_idle = (expected_grants.size() == 0);
  end

  always @(posedge clk_i or negedge rst_ni) begin : send
    bit present;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      present = in_valid_i;
      if (in_xfer) begin
        expected_grants.push_back(predict_grant(current_request));
        present = 1'b0;
      end
      if (!present) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0 &&
                     (!pending_requests[0].wait_idle || (results_idle && !in_xfer))) begin
          current_request = pending_requests.pop_front();
          present = 1'b1;
          opcode_i <= current_request.opcode;
          vector_i <= current_request.vector;
          attributes_i <= current_request.attributes;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 150);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30)
                                                   : $urandom_range(0, 6);
          end
        end
      end
      in_valid_i <= present;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receive
    bit hold_now;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
        rx_period = $urandom_range(2, 8);
        rx_duty = $urandom_range(1, rx_period - 1);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     hold_now = 1'b0;
        RX_RANDOM:   hold_now = ($urandom_range(0, 99) < 35);
        RX_PERIODIC: hold_now = ((rx_tick % rx_period) < rx_duty);
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            hold_now = 1'b1;
          end else begin
            hold_now = 1'b0;
            if ($urandom_range(0, 29) == 0) rx_hold = $urandom_range(5, 40);
          end
        end
      endcase
      out_stall_i <= hold_now;
    end
  end

  always @(posedge clk_i) begin : check
    grant_t want;
    if (rst_ni && out_xfer) begin
      if (expected_grants.size() == 0) begin
        $display("%0t unexpected result: vector %0d status %0d attributes 0x%02h",
                 $time, got_vector, got_status, got_attributes);
        mismatches++;
      end else begin
        want = expected_grants.pop_front();
        if (got_vector !== want.vector) begin
          $display("%0t vector_out mismatch: expected %0d, actual %0d",
                   $time, want.vector, got_vector);
          mismatches++;
        end
        if (got_status !== 2'(want.status)) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, want.status, got_status);
          mismatches++;
        end
        if (got_attributes !== want.attributes) begin
          $display("%0t stored_attributes mismatch: expected 0x%02h, actual 0x%02h",
                   $time, want.attributes, got_attributes);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+design
design/ivalloc_pkg.sv
design/ivalloc_ram.sv
design/ivalloc_ctrl.sv
design/ivalloc_dp.sv
design/interrupt_vector_allocator.sv
design/ivalloc_checker.sv
bench/tb_top.sv
